FILE: sv/fna_pkg.sv
// ----------------------------------------------------------------------------
// fna_pkg: shared definitions for the frame allocator
// Widths, result and command codes, and the structs used between the
// sequencer and the state store.
// ----------------------------------------------------------------------------
package fna_pkg;

   localparam int NUM_FRAMES = 64;
   localparam int FRAME_W    = $clog2(NUM_FRAMES);
   localparam int COUNT_W    = FRAME_W + 1;
   localparam int CSR_ADDR_W = 2;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_TOUCH = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   localparam logic [2:0] KIND_GRANTED  = 3'd0;
   localparam logic [2:0] KIND_EVICTED  = 3'd1;
   localparam logic [2:0] KIND_FAILED   = 3'd2;
   localparam logic [2:0] KIND_FREED    = 3'd3;
   localparam logic [2:0] KIND_FREE_ERR = 3'd4;
   localparam logic [2:0] KIND_TOUCHED  = 3'd5;

   localparam logic [1:0] ACT_NONE      = 2'd0;
   localparam logic [1:0] ACT_WRITEBACK = 2'd1;
   localparam logic [1:0] ACT_DISCARD   = 2'd2;
   localparam logic [1:0] ACT_SWAP      = 2'd3;

   localparam logic [1:0] BACK_ANON = 2'd0;
   localparam logic [1:0] BACK_MMAP = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] REG_FRAMES_IN_USE = '0;

   typedef struct packed {
      logic used;
      logic acc;
      logic dirty;
   } flag_type;

   typedef struct packed {
      logic [7:0]  owner;
      logic [19:0] page;
      logic [1:0]  back;
   } rec_type;

   typedef struct packed {
      logic               rd_en;
      logic [FRAME_W-1:0] rd_addr;
      logic               wr_en;
      logic [FRAME_W-1:0] wr_addr;
      flag_type           wr_data;
   } flag_port_type;

   typedef struct packed {
      logic [FRAME_W-1:0] rd_addr;
      logic               wr_en;
      logic               wr_page_only;
      logic [FRAME_W-1:0] wr_addr;
      rec_type            wr_data;
   } rec_port_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [5:0]  frame_index;
      logic [6:0]  run_length;
      logic [7:0]  owner_id;
      logic [19:0] virtual_page;
      logic [1:0]  backing_kind;
      logic        is_write;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [5:0]  frame_out;
      logic [7:0]  evicted_owner;
      logic [19:0] evicted_page;
      logic [1:0]  evict_action;
      logic        last;
   } rsp_type;

endpackage

FILE: sv/fna_if.sv
// ----------------------------------------------------------------------------
// fna_if: request and response channel interfaces
// Valid/ready channels carrying one word of the allocator's payload.
// ----------------------------------------------------------------------------
interface fna_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [5:0]  frame_index;
   logic [6:0]  run_length;
   logic [7:0]  owner_id;
   logic [19:0] virtual_page;
   logic [1:0]  backing_kind;
   logic        is_write;

   modport source (output valid, cmd, frame_index, run_length, owner_id, virtual_page,
                   backing_kind, is_write, input ready);
   modport sink (input valid, cmd, frame_index, run_length, owner_id, virtual_page,
                 backing_kind, is_write, output ready);
endinterface

interface fna_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [5:0]  frame_out;
   logic [7:0]  evicted_owner;
   logic [19:0] evicted_page;
   logic [1:0]  evict_action;
   logic        last;

   modport source (output valid, kind, frame_out, evicted_owner, evicted_page,
                   evict_action, last, input ready);
   modport sink (input valid, kind, frame_out, evicted_owner, evicted_page,
                 evict_action, last, output ready);
endinterface

FILE: sv/frame_allocator_nru_evict.sv
// ----------------------------------------------------------------------------
// frame_allocator_nru_evict: physical frame allocator with NRU eviction
// Top level: configuration register, sequencer and frame state memories.
// ----------------------------------------------------------------------------
// Commands arrive as words on req_chan: allocate a run, free a run or touch a
// frame. Each command yields one response word on rsp_chan, except that an
// allocate which has to evict first yields an eviction word followed by the
// grant or failure word; the word with last set closes the command. A command
// code of three is swallowed and answers nothing.
// The block handles one command at a time. Each search, clear or free step
// is a read of the flag memory and then its use, so the scans set the
// latency: a touch reads and writes its frame, a free walks its run, and an
// allocate searches for a run and then marks it; an eviction adds a victim
// search, a record read and a second run search.
// Responses sit in an output register, so a new command is taken while the
// last word waits; a stalled receiver holds further words in the sequencer.
// Reset clears the used, accessed and dirty flags through per-frame valid
// bits at once, and sets frames_in_use to 64; no clearing pass is needed.
// The user writes frames_in_use over the csr_ port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module frame_allocator_nru_evict (
   input  logic                            clock,
   input  logic                            reset,
   fna_req_if.sink                         req_chan,
   fna_rsp_if.source                       rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fna_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   logic [fna_pkg::COUNT_W-1:0] frames_in_use_ff, frames_in_use_in;
   logic [fna_pkg::COUNT_W-1:0] pool_size;
   logic                        csr_write;

   fna_pkg::flag_port_type flag_port;
   fna_pkg::flag_type      flag_rd;
   fna_pkg::rec_port_type  rec_port;
   fna_pkg::rec_type       rec_rd;

   // The register sits at byte address zero; writes elsewhere are dropped.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      frames_in_use_in = frames_in_use_ff;
      if (csr_write && csr_paddr == fna_pkg::REG_FRAMES_IN_USE) begin
         frames_in_use_in = csr_pwdata[fna_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= fna_pkg::COUNT_W'(fna_pkg::NUM_FRAMES);
      end else begin
         frames_in_use_ff <= frames_in_use_in;
      end
   end

   assign csr_prdata = (csr_paddr == fna_pkg::REG_FRAMES_IN_USE) ?
                       {{(32 - fna_pkg::COUNT_W){1'b0}}, frames_in_use_ff} : 32'd0;

   // The pool never reaches beyond the physical frame count.
   assign pool_size = (frames_in_use_ff > fna_pkg::COUNT_W'(fna_pkg::NUM_FRAMES)) ?
                      fna_pkg::COUNT_W'(fna_pkg::NUM_FRAMES) : frames_in_use_ff;

   fna_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .pool_size (pool_size),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .flag_port (flag_port),
      .flag_rd   (flag_rd),
      .rec_port  (rec_port),
      .rec_rd    (rec_rd)
   );

   fna_store u_store (
      .clock     (clock),
      .reset     (reset),
      .flag_port (flag_port),
      .flag_rd   (flag_rd),
      .rec_port  (rec_port),
      .rec_rd    (rec_rd)
   );

   // A command that answers keeps the sequencer busy for the next cycle.
   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.cmd != fna_pkg::CMD_NONE)
      |=> !req_chan.ready)
      else $error("sequencer took a second command straight away");

   // Only an eviction word may leave the command open.
   a_last_only_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.last || rsp_chan.kind == fna_pkg::KIND_EVICTED))
      else $error("non-eviction word without last");

   // Words other than evictions carry no eviction records.
   a_clean_non_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kind != fna_pkg::KIND_EVICTED) |->
      (rsp_chan.evicted_owner == '0 && rsp_chan.evicted_page == '0 &&
       rsp_chan.evict_action == fna_pkg::ACT_NONE))
      else $error("eviction fields set on a non-eviction word");

endmodule

FILE: sv/fna_store.sv
// ----------------------------------------------------------------------------
// fna_store: frame state memories
// Flag memory (used, accessed, dirty) with per-entry valid bits, and the
// record memory (owner, page, backing). Both have registered reads.
// ----------------------------------------------------------------------------
module fna_store (
   input  logic                   clock,
   input  logic                   reset,
   input  fna_pkg::flag_port_type flag_port,
   output fna_pkg::flag_type      flag_rd,
   input  fna_pkg::rec_port_type  rec_port,
   output fna_pkg::rec_type       rec_rd
);

   fna_pkg::flag_type flag_mem [fna_pkg::NUM_FRAMES];
   fna_pkg::rec_type  rec_mem  [fna_pkg::NUM_FRAMES];

   logic [fna_pkg::NUM_FRAMES-1:0] valid_ff;
   logic [fna_pkg::NUM_FRAMES-1:0] valid_in;
   fna_pkg::flag_type              flag_q_ff;
   logic                           vld_q_ff;
   fna_pkg::rec_type               rec_q_ff;

   always_comb begin
      valid_in = valid_ff;
      if (flag_port.wr_en) begin
         valid_in[flag_port.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (flag_port.wr_en) begin
         flag_mem[flag_port.wr_addr] <= flag_port.wr_data;
      end
      if (flag_port.rd_en) begin
         flag_q_ff <= flag_mem[flag_port.rd_addr];
         vld_q_ff  <= valid_ff[flag_port.rd_addr];
      end
   end

   // An entry never written reads as all clear.
   assign flag_rd = vld_q_ff ? flag_q_ff : '0;

   always_ff @(posedge clock) begin
      if (rec_port.wr_en) begin
         if (rec_port.wr_page_only) begin
            rec_mem[rec_port.wr_addr].page <= rec_port.wr_data.page;
         end else begin
            rec_mem[rec_port.wr_addr] <= rec_port.wr_data;
         end
      end
      rec_q_ff <= rec_mem[rec_port.rd_addr];
   end

   assign rec_rd = rec_q_ff;

endmodule

FILE: sv/fna_seq.sv
// ----------------------------------------------------------------------------
// fna_seq: command sequencer
// Walks the frame memories one entry at a time for run search, victim
// search, accessed-bit clearing, run marking and freeing, and holds the
// result output register.
// ----------------------------------------------------------------------------
module fna_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [fna_pkg::COUNT_W-1:0]  pool_size,
   fna_req_if.sink                      req_chan,
   fna_rsp_if.source                    rsp_chan,
   output fna_pkg::flag_port_type       flag_port,
   input  fna_pkg::flag_type            flag_rd,
   output fna_pkg::rec_port_type        rec_port,
   input  fna_pkg::rec_type             rec_rd
);

   typedef enum logic [15:0] {
      ST_IDLE     = 16'b0000_0000_0000_0001,
      ST_FR_RD    = 16'b0000_0000_0000_0010,
      ST_FR_CHK   = 16'b0000_0000_0000_0100,
      ST_WR_RUN   = 16'b0000_0000_0000_1000,
      ST_VS_RD    = 16'b0000_0000_0001_0000,
      ST_VS_CHK   = 16'b0000_0000_0010_0000,
      ST_REC_RD   = 16'b0000_0000_0100_0000,
      ST_EV_BLD   = 16'b0000_0000_1000_0000,
      ST_CLR_RD   = 16'b0000_0001_0000_0000,
      ST_CLR_WR   = 16'b0000_0010_0000_0000,
      ST_FREE_RD  = 16'b0000_0100_0000_0000,
      ST_FREE_CHK = 16'b0000_1000_0000_0000,
      ST_TCH_WR   = 16'b0001_0000_0000_0000,
      ST_EMIT     = 16'b0010_0000_0000_0000
   } state_type;

   localparam int CW = fna_pkg::COUNT_W;
   localparam int FW = fna_pkg::FRAME_W;

   state_type          state_ff, state_in, after_ff, after_in;
   fna_pkg::req_type   req_ff, req_in;
   fna_pkg::rsp_type   res_ff, res_in, out_ff, out_in;
   logic               out_valid_ff, out_valid_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [FW-1:0]      start_ff, start_in;
   logic [FW-1:0]      victim_ff, victim_in;
   logic               dirty_ff, dirty_in;
   logic               pass_ff, pass_in;
   logic               err_ff, err_in;

   logic [CW-1:0]      cnt_next;
   logic [CW-1:0]      fr_sum;
   logic [CW:0]        end_sum;
   logic [1:0]         act;
   fna_pkg::rsp_type   res_base;

   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.kind          = out_ff.kind;
   assign rsp_chan.frame_out     = out_ff.frame_out;
   assign rsp_chan.evicted_owner = out_ff.evicted_owner;
   assign rsp_chan.evicted_page  = out_ff.evicted_page;
   assign rsp_chan.evict_action  = out_ff.evict_action;
   assign rsp_chan.last          = out_ff.last;

   always_comb begin
      state_in     = state_ff;
      after_in     = after_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      i_in         = i_ff;
      count_in     = count_ff;
      start_in     = start_ff;
      victim_in    = victim_ff;
      dirty_in     = dirty_ff;
      pass_in      = pass_ff;
      err_in       = err_ff;
      flag_port    = '0;
      rec_port     = '0;
      res_base     = '0;
      res_base.last = 1'b1;
      cnt_next     = flag_rd.used ? '0 : count_ff + 1'b1;
      fr_sum       = {1'b0, req_ff.frame_index} + i_ff;
      end_sum      = {2'b00, req_in.frame_index} + {1'b0, req_in.run_length};
      act          = fna_pkg::ACT_SWAP;

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               req_in.cmd          = req_chan.cmd;
               req_in.frame_index  = req_chan.frame_index;
               req_in.run_length   = req_chan.run_length;
               req_in.owner_id     = req_chan.owner_id;
               req_in.virtual_page = req_chan.virtual_page;
               req_in.backing_kind = req_chan.backing_kind;
               req_in.is_write     = req_chan.is_write;
               end_sum = {2'b00, req_in.frame_index} + {1'b0, req_in.run_length};
               i_in     = '0;
               count_in = '0;
               pass_in  = 1'b0;
               unique case (req_chan.cmd)
                  fna_pkg::CMD_ALLOC: begin
                     if (req_chan.run_length == '0) begin
                        req_in.run_length = CW'(1);
                     end
                     state_in = ST_FR_RD;
                  end
                  fna_pkg::CMD_FREE: begin
                     err_in = ({1'b0, req_chan.frame_index} >= pool_size) ||
                              (end_sum > {1'b0, pool_size});
                     if ({1'b0, req_chan.frame_index} < pool_size) begin
                        rec_port.wr_en        = 1'b1;
                        rec_port.wr_page_only = 1'b1;
                        rec_port.wr_addr      = req_chan.frame_index;
                     end
                     state_in = ST_FREE_RD;
                  end
                  fna_pkg::CMD_TOUCH: begin
                     if ({1'b0, req_chan.frame_index} < pool_size) begin
                        flag_port.rd_en   = 1'b1;
                        flag_port.rd_addr = req_chan.frame_index;
                        state_in = ST_TCH_WR;
                     end else begin
                        res_in           = res_base;
                        res_in.kind      = fna_pkg::KIND_TOUCHED;
                        res_in.frame_out = req_chan.frame_index;
                        after_in         = ST_IDLE;
                        state_in         = ST_EMIT;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_FR_RD: begin
            if (i_ff >= pool_size) begin
               if (pass_ff) begin
                  res_in      = res_base;
                  res_in.kind = fna_pkg::KIND_FAILED;
                  after_in    = ST_IDLE;
                  state_in    = ST_EMIT;
               end else begin
                  i_in     = '0;
                  state_in = ST_VS_RD;
               end
            end else begin
               flag_port.rd_en   = 1'b1;
               flag_port.rd_addr = i_ff[FW-1:0];
               state_in = ST_FR_CHK;
            end
         end

         ST_FR_CHK: begin
            if (cnt_next == req_ff.run_length) begin
               start_in = FW'(i_ff + 1'b1 - req_ff.run_length);
               i_in     = '0;
               state_in = ST_WR_RUN;
            end else begin
               count_in = cnt_next;
               i_in     = i_ff + 1'b1;
               state_in = ST_FR_RD;
            end
         end

         ST_WR_RUN: begin
            flag_port.wr_en   = 1'b1;
            flag_port.wr_addr = FW'({1'b0, start_ff} + i_ff);
            flag_port.wr_data = '{used: 1'b1, acc: 1'b0, dirty: 1'b0};
            if (i_ff == '0) begin
               rec_port.wr_en         = 1'b1;
               rec_port.wr_addr       = start_ff;
               rec_port.wr_data.owner = req_ff.owner_id;
               rec_port.wr_data.page  = req_ff.virtual_page;
               rec_port.wr_data.back  = req_ff.backing_kind;
            end
            if (i_ff + 1'b1 == req_ff.run_length) begin
               res_in           = res_base;
               res_in.kind      = fna_pkg::KIND_GRANTED;
               res_in.frame_out = start_ff;
               after_in         = ST_IDLE;
               state_in         = ST_EMIT;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end

         ST_VS_RD: begin
            if (i_ff >= pool_size) begin
               i_in     = '0;
               state_in = ST_CLR_RD;
            end else begin
               flag_port.rd_en   = 1'b1;
               flag_port.rd_addr = i_ff[FW-1:0];
               state_in = ST_VS_CHK;
            end
         end

         ST_VS_CHK: begin
            if (flag_rd.used && !flag_rd.acc) begin
               victim_in = i_ff[FW-1:0];
               dirty_in  = flag_rd.dirty;
               state_in  = ST_REC_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_VS_RD;
            end
         end

         ST_REC_RD: begin
            rec_port.rd_addr = victim_ff;
            state_in = ST_EV_BLD;
         end

         ST_EV_BLD: begin
            if (rec_rd.back >= fna_pkg::BACK_MMAP && dirty_ff) begin
               act = fna_pkg::ACT_WRITEBACK;
            end else if (!dirty_ff && rec_rd.back != fna_pkg::BACK_ANON) begin
               act = fna_pkg::ACT_DISCARD;
            end
            res_in               = res_base;
            res_in.kind          = fna_pkg::KIND_EVICTED;
            res_in.frame_out     = victim_ff;
            res_in.evicted_owner = rec_rd.owner;
            res_in.evicted_page  = rec_rd.page;
            res_in.evict_action  = act;
            res_in.last          = 1'b0;
            flag_port.wr_en      = 1'b1;
            flag_port.wr_addr    = victim_ff;
            flag_port.wr_data    = '0;
            rec_port.wr_en        = 1'b1;
            rec_port.wr_page_only = 1'b1;
            rec_port.wr_addr      = victim_ff;
            pass_in  = 1'b1;
            i_in     = '0;
            count_in = '0;
            after_in = ST_FR_RD;
            state_in = ST_EMIT;
         end

         ST_CLR_RD: begin
            if (i_ff >= pool_size) begin
               res_in      = res_base;
               res_in.kind = fna_pkg::KIND_FAILED;
               after_in    = ST_IDLE;
               state_in    = ST_EMIT;
            end else begin
               flag_port.rd_en   = 1'b1;
               flag_port.rd_addr = i_ff[FW-1:0];
               state_in = ST_CLR_WR;
            end
         end

         ST_CLR_WR: begin
            flag_port.wr_en   = 1'b1;
            flag_port.wr_addr = i_ff[FW-1:0];
            flag_port.wr_data = '{used: flag_rd.used, acc: 1'b0, dirty: flag_rd.dirty};
            i_in     = i_ff + 1'b1;
            state_in = ST_CLR_RD;
         end

         ST_FREE_RD: begin
            if (i_ff >= req_ff.run_length || fr_sum >= pool_size) begin
               res_in           = res_base;
               res_in.kind      = err_ff ? fna_pkg::KIND_FREE_ERR : fna_pkg::KIND_FREED;
               res_in.frame_out = req_ff.frame_index;
               after_in         = ST_IDLE;
               state_in         = ST_EMIT;
            end else begin
               flag_port.rd_en   = 1'b1;
               flag_port.rd_addr = fr_sum[FW-1:0];
               state_in = ST_FREE_CHK;
            end
         end

         ST_FREE_CHK: begin
            if (!flag_rd.used) begin
               err_in = 1'b1;
            end
            flag_port.wr_en   = 1'b1;
            flag_port.wr_addr = fr_sum[FW-1:0];
            flag_port.wr_data = '{used: 1'b0, acc: flag_rd.acc, dirty: flag_rd.dirty};
            i_in     = i_ff + 1'b1;
            state_in = ST_FREE_RD;
         end

         ST_TCH_WR: begin
            flag_port.wr_en   = 1'b1;
            flag_port.wr_addr = req_ff.frame_index;
            flag_port.wr_data = '{used: flag_rd.used, acc: 1'b1,
                                  dirty: flag_rd.dirty | req_ff.is_write};
            res_in           = res_base;
            res_in.kind      = fna_pkg::KIND_TOUCHED;
            res_in.frame_out = req_ff.frame_index;
            after_in         = ST_IDLE;
            state_in         = ST_EMIT;
         end

         ST_EMIT: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = after_ff;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         after_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         after_ff     <= after_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      res_ff    <= res_in;
      out_ff    <= out_in;
      i_ff      <= i_in;
      count_ff  <= count_in;
      start_ff  <= start_in;
      victim_ff <= victim_in;
      dirty_ff  <= dirty_in;
      pass_ff   <= pass_in;
      err_ff    <= err_in;
   end

endmodule
